// ----- src/tos_pkg.sv -----
// ----------------------------------------------------------------------------
// tos_pkg
// Shared types, codes and helpers for the typed operand stack.
// ----------------------------------------------------------------------------
package tos_pkg;

    // sizes
    localparam int SLOT_DEPTH_DEF = 512;
    localparam int SLOT_W         = 32;
    localparam int VALUE_W        = 64;
    localparam int COUNT_OUT_W    = 10;
    localparam int VLIMIT_W       = 9;
    localparam int TYPE_W         = 3;
    localparam int RTYPE_W        = 4;
    localparam int OP_W           = 2;
    localparam int STATUS_W       = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH       = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_TYPED = 2'd1;
    localparam logic [OP_W-1:0] OP_POP        = 2'd2;
    localparam logic [OP_W-1:0] OP_PEEK       = 2'd3;

    // value type codes
    localparam logic [TYPE_W-1:0] VT_INT    = 3'd0;
    localparam logic [TYPE_W-1:0] VT_FLOAT  = 3'd1;
    localparam logic [TYPE_W-1:0] VT_LONG   = 3'd2;
    localparam logic [TYPE_W-1:0] VT_DOUBLE = 3'd3;
    localparam logic [TYPE_W-1:0] VT_BOOL   = 3'd4;
    localparam logic [TYPE_W-1:0] VT_REF    = 3'd5;
    localparam logic [TYPE_W-1:0] VT_NONE   = 3'd7;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd3;

    // register indexes
    localparam logic REG_WIDE_REFS   = 1'b0;
    localparam logic REG_VALUE_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_HI,
        S_READ_TOP,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic wr_lo;
        logic wr_hi;
        logic rd_top;
        logic rd_below;
        logic cap_top;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_push;
        logic push_ok;
        logic push_two;
        logic stack_empty;
        logic out_busy;
    } t_status;

    // value takes a low and a high slot
    function automatic logic takes_two(input logic [TYPE_W-1:0] t, input logic wide);
        takes_two = (t == VT_LONG) || (t == VT_DOUBLE) || ((t == VT_REF) && wide);
    endfunction

endpackage

// ----- src/tos_ctrl.sv -----
// ----------------------------------------------------------------------------
// tos_ctrl
// Sequencer for the operand stack: steps each request through decode,
// memory accesses and result hand-off.
// ----------------------------------------------------------------------------
module tos_ctrl
    import tos_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_status.is_push) begin
                    if (i_status.push_ok && i_status.push_two) n_state = S_PUSH_HI;
                    else                                       n_state = S_FINISH;
                end else begin
                    if (i_status.stack_empty) n_state = S_FINISH;
                    else                      n_state = S_READ_TOP;
                end
            end
            S_PUSH_HI:  n_state = S_FINISH;
            S_READ_TOP: n_state = S_FINISH;
            S_FINISH: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.wr_lo  = i_status.is_push && i_status.push_ok;
                o_cmd.rd_top = !i_status.is_push && !i_status.stack_empty;
            end
            S_PUSH_HI: begin
                o_cmd.wr_hi = 1'b1;
            end
            S_READ_TOP: begin
                o_cmd.cap_top  = 1'b1;
                o_cmd.rd_below = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- src/tos_dp.sv -----
// ----------------------------------------------------------------------------
// tos_dp
// Operand stack datapath: slot and tag memories, counters, request
// registers and the result register.
// ----------------------------------------------------------------------------
module tos_dp
    import tos_pkg::*;
#(
    parameter int SLOT_DEPTH = SLOT_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    // config
    input  logic                   i_wide_refs,
    input  logic [VLIMIT_W-1:0]    i_value_limit,
    // request
    input  logic [OP_W-1:0]        i_op,
    input  logic [VALUE_W-1:0]     i_push_value,
    input  logic [TYPE_W-1:0]      i_value_type,
    input  logic [RTYPE_W-1:0]     i_given_real_type,
    // result
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [VALUE_W-1:0]     o_result_value,
    output logic [TYPE_W-1:0]      o_result_type,
    output logic [RTYPE_W-1:0]     o_result_real_type,
    output logic [STATUS_W-1:0]    o_status_code,
    output logic [COUNT_OUT_W-1:0] o_slot_count
);

    localparam int AW    = $clog2(SLOT_DEPTH);
    localparam int CW    = $clog2(SLOT_DEPTH + 1);
    localparam int LW    = ((CW > VLIMIT_W + 1) ? CW : (VLIMIT_W + 1)) + 1;
    localparam int TAG_W = RTYPE_W + TYPE_W;

    // request registers
    logic [OP_W-1:0]    r_op;
    logic [VALUE_W-1:0] r_pv;
    logic [TYPE_W-1:0]  r_vt;
    logic [RTYPE_W-1:0] r_grt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_op;
            r_pv  <= i_push_value;
            r_vt  <= i_value_type;
            r_grt <= i_given_real_type;
        end
    end

    // counters
    logic [CW-1:0] r_su;
    logic [CW-1:0] r_vu;
    logic [CW-1:0] n_su;
    logic [CW-1:0] n_vu;

    // push checks
    logic          is_push;
    logic          type_bad;
    logic          push_two;
    logic [LW-1:0] lim2;
    logic [LW-1:0] limit;
    logic [LW-1:0] need_end;
    logic          overflow;
    logic          push_ok;
    logic          stack_empty;

    assign is_push     = (r_op == OP_PUSH) || (r_op == OP_PUSH_TYPED);
    assign type_bad    = r_vt > VT_REF;
    assign push_two    = takes_two(r_vt, i_wide_refs);
    assign lim2        = LW'({i_value_limit, 1'b0});
    assign limit       = (lim2 > LW'(SLOT_DEPTH)) ? LW'(SLOT_DEPTH) : lim2;
    assign need_end    = LW'(r_su) + (push_two ? LW'(2) : LW'(1));
    assign overflow    = (need_end > limit) || (r_vu >= CW'(SLOT_DEPTH));
    assign push_ok     = !type_bad && !overflow;
    assign stack_empty = (r_su == '0) || (r_vu == '0);

    // low slot word, bools folded to 0/1
    logic [SLOT_W-1:0]  lo_word;
    logic [RTYPE_W-1:0] push_rtype;

    assign lo_word    = (r_vt == VT_BOOL) ? SLOT_W'(r_pv[7:0] != 8'd0)
                                          : r_pv[SLOT_W-1:0];
    assign push_rtype = (r_op == OP_PUSH_TYPED) ? r_grt : RTYPE_W'(r_vt);

    // slot memory, one port
    logic [SLOT_W-1:0] r_slot_mem [SLOT_DEPTH];
    logic [SLOT_W-1:0] r_slot_rd;
    logic [AW-1:0]     slot_addr;
    logic [SLOT_W-1:0] slot_wdata;
    logic              slot_we;
    logic              slot_re;
    logic              below_ok;

    assign below_ok = r_su >= CW'(2);
    assign slot_we  = i_cmd.wr_lo || i_cmd.wr_hi;
    assign slot_re  = i_cmd.rd_top || (i_cmd.rd_below && below_ok);

    always_comb begin
        slot_addr  = r_su[AW-1:0];
        slot_wdata = lo_word;
        if (i_cmd.wr_hi) begin
            slot_addr  = r_su[AW-1:0] + AW'(1);
            slot_wdata = r_pv[VALUE_W-1:SLOT_W];
        end else if (i_cmd.rd_top) begin
            slot_addr = r_su[AW-1:0] - AW'(1);
        end else if (i_cmd.rd_below) begin
            slot_addr = r_su[AW-1:0] - AW'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) r_slot_mem[slot_addr] <= slot_wdata;
        if (slot_re) r_slot_rd <= r_slot_mem[slot_addr];
    end

    // tag memory: {real type, type}, one port
    logic [TAG_W-1:0] r_tag_mem [SLOT_DEPTH];
    logic [TAG_W-1:0] r_tag_rd;
    logic [AW-1:0]    tag_addr;

    assign tag_addr = i_cmd.rd_top ? (r_vu[AW-1:0] - AW'(1)) : r_vu[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_lo)  r_tag_mem[tag_addr] <= {push_rtype, r_vt};
        if (i_cmd.rd_top) r_tag_rd <= r_tag_mem[tag_addr];
    end

    // top of stack capture
    logic [SLOT_W-1:0] r_top;
    logic [TAG_W-1:0]  r_top_tag;
    logic              r_below_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_top) begin
            r_top      <= r_slot_rd;
            r_top_tag  <= r_tag_rd;
            r_below_ok <= below_ok;
        end
    end

    // result forming
    logic [TYPE_W-1:0]   head_type;
    logic                pop_two;
    logic [SLOT_W-1:0]   below_word;
    logic [VALUE_W-1:0]  res_value;
    logic [TYPE_W-1:0]   res_type;
    logic [RTYPE_W-1:0]  res_rtype;
    logic [STATUS_W-1:0] res_status;

    assign head_type  = r_top_tag[TYPE_W-1:0];
    assign pop_two    = takes_two(head_type, i_wide_refs);
    assign below_word = r_below_ok ? r_slot_rd : '0;

    always_comb begin
        res_value  = '0;
        res_type   = VT_NONE;
        res_rtype  = '0;
        res_status = ST_OK;
        n_su       = r_su;
        n_vu       = r_vu;
        if (is_push) begin
            if (type_bad) begin
                res_status = ST_INVALID;
            end else if (overflow) begin
                res_status = ST_OVERFLOW;
            end else begin
                n_su = need_end[CW-1:0];
                n_vu = r_vu + CW'(1);
            end
        end else if (stack_empty) begin
            res_status = ST_EMPTY;
        end else begin
            res_type  = head_type;
            res_rtype = r_top_tag[TAG_W-1:TYPE_W];
            res_value = pop_two ? {r_top, below_word} : VALUE_W'(r_top);
            if (r_op == OP_POP) begin
                if (pop_two) n_su = (r_su > CW'(2)) ? (r_su - CW'(2)) : '0;
                else         n_su = r_su - CW'(1);
                n_vu = r_vu - CW'(1);
                if ((n_su == '0) || (n_vu == '0)) begin
                    n_su = '0;
                    n_vu = '0;
                end
            end
        end
    end

    // counters and output valid
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_su        <= '0;
            r_vu        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_su        <= n_su;
                r_vu        <= n_vu;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    logic [VALUE_W-1:0]     r_res_value;
    logic [TYPE_W-1:0]      r_res_type;
    logic [RTYPE_W-1:0]     r_res_rtype;
    logic [STATUS_W-1:0]    r_res_status;
    logic [COUNT_OUT_W-1:0] r_res_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_res_value  <= res_value;
            r_res_type   <= res_type;
            r_res_rtype  <= res_rtype;
            r_res_status <= res_status;
            r_res_count  <= COUNT_OUT_W'(n_su);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_value     = r_res_value;
    assign o_result_type      = r_res_type;
    assign o_result_real_type = r_res_rtype;
    assign o_status_code      = r_res_status;
    assign o_slot_count       = r_res_count;

    // status to controller
    assign o_status.is_push     = is_push;
    assign o_status.push_ok     = push_ok;
    assign o_status.push_two    = push_two;
    assign o_status.stack_empty = stack_empty;
    assign o_status.out_busy    = r_out_valid && !i_out_ready;

endmodule

// ----- src/typed_operand_stack_core.sv -----
// ----------------------------------------------------------------------------
// typed_operand_stack_core
// Operand stack of 32-bit slots with a type and real-type tag per value.
//
// Requests enter on the s_axis channel: push (default or given real type),
// pop or peek. Each request yields exactly one result on m_axis with the
// value, its tags, a status code and the slot count after the request.
// Long, double and (with wide references on) references take two slots.
// Two registers sit behind the APB port: wide references at 0x0 and the
// value limit at 0x4 (slot limit is twice the value limit, at most SLOT_DEPTH).
// Each request steps through idle, decode, then a high-slot write (two-slot
// pushes) or a top-of-stack read (pops and peeks), and finish; one-slot
// pushes and refused or empty requests go from decode straight to finish.
// The next request is taken only back in idle; the single-port slot memory
// with registered read sets this sequence. A finished result waits in the
// output register; a stalled receiver holds the block in its final step
// until it takes the result. Reset empties the stack and restores register
// defaults; the slot memory itself is not cleared.
// ----------------------------------------------------------------------------
module typed_operand_stack_core
    import tos_pkg::*;
#(
    parameter int SLOT_DEPTH = SLOT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [1:0] op, [65:2] push_value, [68:66] value_type,
    // [72:69] given_real_type, [79:73] zero
    input  logic [79:0] i_s_axis_tdata,
    // result channel
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [63:0] result_value, [66:64] result_type, [70:67] result_real_type,
    // [72:71] status, [82:73] slot_count, [87:83] zero
    output logic [87:0] o_m_axis_tdata,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // config registers
    logic                r_wide_refs;
    logic [VLIMIT_W-1:0] r_value_limit;
    logic                cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_refs   <= 1'b0;
            r_value_limit <= VLIMIT_W'(256);
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WIDE_REFS:   r_wide_refs   <= pwdata[0];
                REG_VALUE_LIMIT: r_value_limit <= pwdata[VLIMIT_W-1:0];
                default:         r_wide_refs   <= r_wide_refs;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[2])
            REG_WIDE_REFS:   prdata = 32'(r_wide_refs);
            REG_VALUE_LIMIT: prdata = 32'(r_value_limit);
            default:         prdata = '0;
        endcase
    end

    // controller and datapath
    t_cmd    cmd;
    t_status status;

    logic [VALUE_W-1:0]     result_value;
    logic [TYPE_W-1:0]      result_type;
    logic [RTYPE_W-1:0]     result_real_type;
    logic [STATUS_W-1:0]    status_code;
    logic [COUNT_OUT_W-1:0] slot_count;

    tos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    tos_dp #(
        .SLOT_DEPTH (SLOT_DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_wide_refs        (r_wide_refs),
        .i_value_limit      (r_value_limit),
        .i_op               (i_s_axis_tdata[1:0]),
        .i_push_value       (i_s_axis_tdata[65:2]),
        .i_value_type       (i_s_axis_tdata[68:66]),
        .i_given_real_type  (i_s_axis_tdata[72:69]),
        .i_out_ready        (i_m_axis_tready),
        .o_out_valid        (o_m_axis_tvalid),
        .o_result_value     (result_value),
        .o_result_type      (result_type),
        .o_result_real_type (result_real_type),
        .o_status_code      (status_code),
        .o_slot_count       (slot_count)
    );

    assign o_m_axis_tdata = {5'd0, slot_count, status_code, result_real_type,
                             result_type, result_value};

endmodule
